FILE: sv/lmh_pkg.sv
`default_nettype none
package lmh_pkg;

	// murmur2 mixing constant and shift amounts
	localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
	localparam int unsigned MIX_SHIFT   = 24;
	localparam int unsigned FIN_SHIFT_A = 13;
	localparam int unsigned FIN_SHIFT_B = 15;
	localparam logic [31:0] SEED_RESET  = 32'h31415926;

	// string length limit, lengths above it saturate
	localparam int unsigned MAX_LEN   = 31;
	localparam int unsigned LEN_W     = 5;
	localparam logic [7:0]  MAX_LEN_B = 8'(MAX_LEN);
	localparam logic [LEN_W-1:0] MAX_LEN_L = LEN_W'(MAX_LEN);

	// configuration register indexes
	localparam logic REG_HASH_SEED = 1'b0;
	localparam logic REG_FOLD_CASE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIX_K1,
		ST_MIX_K2,
		ST_MIX_H,
		ST_FIN_TAIL,
		ST_FIN_AVAL
	} state_t;

	// operation of the shared multiply unit
	typedef enum logic [2:0] {
		OP_K1,
		OP_K2,
		OP_H,
		OP_TAIL,
		OP_AVAL
	} mul_op_t;

endpackage
`default_nettype wire

FILE: sv/lmh_mul_unit.sv
`default_nettype none
module lmh_mul_unit (
	input  wire lmh_pkg::mul_op_t op,
	input  wire logic [31:0]      h,
	input  wire logic [31:0]      k,
	input  wire logic [23:0]      pend,
	output logic [31:0]           res
);
	import lmh_pkg::*;

	logic [31:0] opnd;
	logic [31:0] prod;

	// operand select
	always_comb begin
		case (op)
			OP_K1:   opnd = k;
			OP_K2:   opnd = k;
			OP_H:    opnd = h;
			OP_TAIL: opnd = h ^ {8'h00, pend};
			OP_AVAL: opnd = h ^ (h >> FIN_SHIFT_A);
			default: opnd = h;
		endcase
	end

	// single 32x32 multiplier, low word kept
	assign prod = opnd * MIX_MUL;

	// post-multiply xor step (none for K2 and TAIL)
	always_comb begin
		case (op)
			OP_K1:   res = prod ^ (prod >> MIX_SHIFT);
			OP_K2:   res = prod;
			OP_H:    res = prod ^ k;
			OP_TAIL: res = prod;
			OP_AVAL: res = prod ^ (prod >> FIN_SHIFT_B);
			default: res = prod;
		endcase
	end

endmodule
`default_nettype wire

FILE: sv/lowercase_murmur2_string_hash.sv
// a byte that does not complete a 4-byte group is only stored in the pending group; one that completes
// a group is loaded and then passes the shared multiplier in MIX_K1, MIX_K2 and MIX_H
// the last item adds the avalanche, preceded by the tail step if a 1 to 3 byte tail is pending,
// after which the hash sits in the output register; no new byte is accepted until the sequencer is idle
// asynchronous active-low reset clears control and hash state except the group word, seed returns to
// 0x31415926 and case folding is on
`default_nettype none
module lowercase_murmur2_string_hash (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input item stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [7:0] char_byte, [12:8] str_length, rest zero
	input  wire logic        s_axis_tuser,  // first_byte
	input  wire logic        s_axis_tlast,  // last_byte
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // [31:0] hash_value
	// configuration writes
	input  wire logic        cfg_we,
	input  wire logic        cfg_addr,
	input  wire logic [31:0] cfg_data
);
	import lmh_pkg::*;

	state_t state_q, state_d;

	// configuration registers
	logic [31:0] seed_q;
	logic        fold_q;

	// hash state
	logic [31:0]      h_q;
	logic [31:0]      k_q;
	logic [23:0]      pend_q;
	logic [1:0]       cnt_q;
	logic [LEN_W-1:0] taken_q;
	logic [LEN_W-1:0] len_q;
	logic             last_q;

	// output register
	logic        m_valid_q;
	logic [31:0] m_data_q;

	// input fields
	logic [7:0]       c_in;
	logic [LEN_W-1:0] len_in;
	logic             first_in;
	logic             last_in;
	logic             acc;

	// state seen by the incoming byte, after a first item restarts it
	logic [LEN_W-1:0] len_sat;
	logic [31:0]      h_eff;
	logic [23:0]      pend_eff;
	logic [1:0]       cnt_eff;
	logic [LEN_W-1:0] taken_eff;
	logic [LEN_W-1:0] len_eff;
	logic             take;
	logic [7:0]       c_fold;
	logic             word_done;
	logic [23:0]      pend_add;
	logic [1:0]       cnt_new;

	logic    out_free;
	mul_op_t mul_op;
	logic [31:0] mul_res;

	assign c_in     = s_axis_tdata[7:0];
	assign len_in   = s_axis_tdata[12:8];
	assign first_in = s_axis_tuser;
	assign last_in  = s_axis_tlast;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign out_free      = !m_valid_q || m_axis_tready;

	// length saturation and restart on a first item
	assign len_sat   = ({3'b000, len_in} > MAX_LEN_B) ? MAX_LEN_L : len_in;
	assign h_eff     = first_in ? (seed_q ^ {27'd0, len_sat}) : h_q;
	assign pend_eff  = first_in ? 24'd0 : pend_q;
	assign cnt_eff   = first_in ? 2'd0 : cnt_q;
	assign taken_eff = first_in ? '0 : taken_q;
	assign len_eff   = first_in ? len_sat : len_q;

	// bytes past the held length are dropped
	assign take = (taken_eff < len_eff);

	// ascii A..Z to a..z when folding is on
	assign c_fold = (fold_q && c_in >= 8'h41 && c_in <= 8'h5A) ? (c_in + 8'h20) : c_in;

	assign word_done = take && (cnt_eff == 2'd3);
	assign cnt_new   = take ? (cnt_eff + 2'd1) : cnt_eff;

	// little-endian placement of the byte into the pending group
	always_comb begin
		case (cnt_eff)
			2'd0:    pend_add = {16'd0, c_fold};
			2'd1:    pend_add = {8'd0, c_fold, 8'd0};
			2'd2:    pend_add = {c_fold, 16'd0};
			default: pend_add = 24'd0;
		endcase
	end

	// shared multiplier operation per state
	always_comb begin
		case (state_q)
			ST_MIX_K1:   mul_op = OP_K1;
			ST_MIX_K2:   mul_op = OP_K2;
			ST_MIX_H:    mul_op = OP_H;
			ST_FIN_TAIL: mul_op = OP_TAIL;
			ST_FIN_AVAL: mul_op = OP_AVAL;
			default:     mul_op = OP_H;
		endcase
	end

	lmh_mul_unit u_mul (
		.op   (mul_op),
		.h    (h_q),
		.k    (k_q),
		.pend (pend_q),
		.res  (mul_res)
	);

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (word_done) begin
						state_d = ST_MIX_K1;
					end else if (last_in) begin
						state_d = (cnt_new != 2'd0) ? ST_FIN_TAIL : ST_FIN_AVAL;
					end
				end
			end
			ST_MIX_K1:   state_d = ST_MIX_K2;
			ST_MIX_K2:   state_d = ST_MIX_H;
			ST_MIX_H:    state_d = last_q ? ST_FIN_AVAL : ST_IDLE;
			ST_FIN_TAIL: state_d = ST_FIN_AVAL;
			ST_FIN_AVAL: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
			fold_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_HASH_SEED: seed_q <= cfg_data;
				REG_FOLD_CASE: fold_q <= cfg_data[0];
				default:       ;
			endcase
		end
	end

	// hash state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q     <= '0;
			pend_q  <= '0;
			cnt_q   <= '0;
			taken_q <= '0;
			len_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						h_q     <= h_eff;
						len_q   <= len_eff;
						last_q  <= last_in;
						taken_q <= take ? (taken_eff + LEN_W'(1)) : taken_eff;
						if (word_done) begin
							pend_q <= '0;
							cnt_q  <= '0;
						end else begin
							pend_q <= take ? (pend_eff | pend_add) : pend_eff;
							cnt_q  <= cnt_new;
						end
					end
				end
				ST_MIX_H:    h_q <= mul_res;
				ST_FIN_TAIL: h_q <= mul_res;
				ST_FIN_AVAL: begin
					// result leaves, state back to reset values
					if (out_free) begin
						h_q     <= '0;
						pend_q  <= '0;
						cnt_q   <= '0;
						taken_q <= '0;
						len_q   <= '0;
						last_q  <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// group word and mix temporaries, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && word_done) begin
			k_q <= {c_fold, pend_eff};
		end else if (state_q == ST_MIX_K1 || state_q == ST_MIX_K2) begin
			k_q <= mul_res;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_FIN_AVAL && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN_AVAL && out_free) begin
			m_data_q <= mul_res;
		end
	end

	// checks
	a_taken_bound: assert property (@(posedge clk) disable iff (!arst_n)
		taken_q <= len_q)
		else $error("more bytes counted than the held length");

	a_k1_to_k2: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MIX_K1 |=> state_q == ST_MIX_K2)
		else $error("mix sequence broken after first k multiply");

	a_mix_empties_group: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MIX_H |-> (cnt_q == 2'd0 && pend_q == 24'd0))
		else $error("pending bytes left while mixing a full group");

	a_result_needs_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN_AVAL && out_free |=> m_axis_tvalid && state_q == ST_IDLE)
		else $error("avalanche finished without a result");

endmodule
`default_nettype wire
